>>> rtl/ritoa_pkg.sv
`default_nettype none
package ritoa_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] MODE_DEC = 2'd0;
  localparam logic [1:0] MODE_OCT = 2'd1;
  localparam logic [1:0] MODE_HEX = 2'd2;
  localparam logic [1:0] MODE_BIN = 2'd3;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam int DEC_DIGITS = 10;
  localparam int OCT_DIGITS = 11;
  localparam int HEX_DIGITS = 16;
  localparam int BIN_DIGITS = 32;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_t;

  // Classified job handed from the front to the back.
  typedef struct packed {
    logic [1:0]  mode;
    logic        neg;
    logic [63:0] mag;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d <= 4'd9) begin
      c = CHAR_ZERO + {4'b0, d};
    end else begin
      c = CHAR_A + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ritoa_front.sv
`default_nettype none
module ritoa_front #(
  parameter int DEPTH = 2
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  output logic            full,
  input  ritoa_pkg::in_t  item,
  output logic            job_valid,
  input  wire             job_take,
  output ritoa_pkg::job_t job
);
  import ritoa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             queue [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  job_t             classified;
  logic             do_push;
  logic             do_pop;
  logic [31:0]      lo;

  // Signed modes take the two's complement magnitude; the most negative
  // value wraps to 2^31, which is exactly its magnitude.
  always_comb begin
    lo = item.value[31:0];
    classified.mode = item.mode;
    classified.neg  = 1'b0;
    classified.mag  = {32'b0, lo};
    if (item.mode == MODE_HEX) begin
      classified.mag = item.value;
    end else if ((item.mode == MODE_DEC || item.mode == MODE_OCT) && lo[31]) begin
      classified.neg = 1'b1;
      classified.mag = {32'b0, (~lo) + 32'd1};
    end
  end

  assign full      = (count == CNT_W'(DEPTH));
  assign job_valid = (count != '0);
  assign job       = queue[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = job_take && job_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/ritoa_back.sv
`default_nettype none
module ritoa_back (
  input  wire             clk,
  input  wire             rst,
  input  wire             job_valid,
  output logic            job_take,
  input  ritoa_pkg::job_t job,
  output logic            empty,
  input  wire             pop,
  output ritoa_pkg::out_t result
);
  import ritoa_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DABBLE = 3'd1;
  localparam logic [2:0] ST_SKIP   = 3'd2;
  localparam logic [2:0] ST_SIGN   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]  state;
  logic [1:0]  mode;
  logic        neg;
  logic [63:0] word;
  logic [5:0]  ndig;
  logic [31:0] bin;
  logic [39:0] bcd;
  logic [4:0]  cnt;
  logic        out_valid;
  out_t        out_q;

  logic [39:0] bcd_adj;
  logic [39:0] bcd_next;
  logic [3:0]  top_digit;
  logic [63:0] word_shifted;
  logic        slot_free;
  logic        char_load;

  // Double dabble step: bump every BCD nibble that is 5 or more by 3.
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
    bcd_next = {bcd_adj[38:0], bin[31]};
  end

  // Digits are kept left aligned in word, so the leading digit is always on top.
  always_comb begin
    unique case (mode)
      MODE_BIN: begin
        top_digit    = {3'b0, word[63]};
        word_shifted = {word[62:0], 1'b0};
      end
      MODE_OCT: begin
        top_digit    = {1'b0, word[63:61]};
        word_shifted = {word[60:0], 3'b0};
      end
      default: begin
        top_digit    = word[63:60];
        word_shifted = {word[59:0], 4'b0};
      end
    endcase
  end

  assign slot_free = !out_valid || pop;
  assign char_load = ((state == ST_SIGN) || (state == ST_EMIT)) && slot_free;
  assign job_take  = (state == ST_IDLE) && job_valid;
  assign empty     = !out_valid;
  assign result    = out_q;

  // A new character takes the slot in the same cycle the old one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (char_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            mode <= job.mode;
            neg  <= job.neg;
            unique case (job.mode)
              MODE_DEC: begin
                bin   <= job.mag[31:0];
                bcd   <= '0;
                cnt   <= '0;
                state <= ST_DABBLE;
              end
              MODE_OCT: begin
                word  <= {job.mag[32:0], 31'b0};
                ndig  <= 6'(OCT_DIGITS);
                state <= ST_SKIP;
              end
              MODE_HEX: begin
                word  <= job.mag;
                ndig  <= 6'(HEX_DIGITS);
                state <= ST_SKIP;
              end
              default: begin
                word  <= {job.mag[31:0], 32'b0};
                ndig  <= 6'(BIN_DIGITS);
                state <= ST_SKIP;
              end
            endcase
          end
        end
        ST_DABBLE: begin
          bcd <= bcd_next;
          bin <= {bin[30:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            word  <= {bcd_next, 24'b0};
            ndig  <= 6'(DEC_DIGITS);
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (ndig > 6'd1 && top_digit == 4'd0) begin
            word <= word_shifted;
            ndig <= ndig - 6'd1;
          end else begin
            state <= neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            out_q.char_code <= CHAR_MINUS;
            out_q.last      <= 1'b0;
            state           <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_q.char_code <= digit_char(top_digit);
            out_q.last      <= (ndig == 6'd1);
            word            <= word_shifted;
            ndig            <= ndig - 6'd1;
            if (ndig == 6'd1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/radix_integer_to_ascii_top.sv
// Channel   Handshake      Payload                     Transaction when
// input     push / full    item  (mode, value)         push && !full
// result    empty / pop    result (char_code, last)    pop && !empty
//
// A run in the converter steps through double dabble (decimal only, one step
// per cycle), then skips the leading zeros (one per cycle), then emits an
// optional minus sign and the digit characters.
// The input queue holds QUEUE_DEPTH classified items, so input keeps flowing
// while a run is emitted. A stalled result holds; the converter waits on it.
// Reset is synchronous and empties the queue and the result register.
`default_nettype none
module radix_integer_to_ascii_top #(
  parameter int QUEUE_DEPTH = ritoa_pkg::QUEUE_DEPTH
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  output logic            full,
  input  ritoa_pkg::in_t  item,
  output logic            empty,
  input  wire             pop,
  output ritoa_pkg::out_t result
);
  import ritoa_pkg::*;

  job_t job;
  logic job_valid;
  logic job_take;

  ritoa_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .job_valid(job_valid),
    .job_take (job_take),
    .job      (job)
  );

  ritoa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job_take (job_take),
    .job      (job),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
`default_nettype wire

>>> rtl/ritoa_checker.sv
`default_nettype none
module ritoa_checker (
  input wire             clk,
  input wire             rst,
  input wire             push,
  input wire             full,
  input ritoa_pkg::in_t  item,
  input wire             empty,
  input wire             pop,
  input ritoa_pkg::out_t result
);
  import ritoa_pkg::*;

  // After reset there is nothing to deliver and room to take a transaction.
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queue not clear after reset");

  // An accepted input transaction carries a fully known payload.
  a_item_known: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |-> !$isunknown(item))
    else $error("accepted item has unknown bits");

  // A result that is not taken stays and holds its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("pending result changed");

  // A minus sign always leads a run and never ends one.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.char_code == CHAR_MINUS) |-> !result.last)
    else $error("run ends on a minus sign");

endmodule

bind radix_integer_to_ascii_top ritoa_checker u_ritoa_checker (
  .clk   (clk),
  .rst   (rst),
  .push  (push),
  .full  (full),
  .item  (item),
  .empty (empty),
  .pop   (pop),
  .result(result)
);
`default_nettype wire

>>> tb/radix_integer_to_ascii_top_tb.sv
`timescale 1ns / 1ps
module radix_integer_to_ascii_top_tb;
  import ritoa_pkg::*;

  localparam int NUM_RANDOM   = 207;
  localparam int CALM_ITEMS   = 40;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  in_t  item_d = '0;
  logic full;
  logic empty;
  out_t result_q;

  in_t  items_to_send[$];
  out_t expected_chars[$];
  int   mismatches = 0;
  int   errors = 0;
  int   quiet_cycles = 0;
  int   send_gap = 0;
  int   pop_gap = 0;
  logic calm;

  radix_integer_to_ascii_top u_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item_d),
    .empty (empty),
    .pop   (pop),
    .result(result_q)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The tail of the run goes without idling on either side.
  assign calm = (items_to_send.size() < CALM_ITEMS);

  // Appends the characters that one number produces to the expected stream.
  function automatic void expand_digits(in_t it);
    logic [63:0] mag;
    logic [63:0] radix;
    logic [63:0] rem;
    logic [31:0] lo;
    logic        neg;
    logic [3:0]  digs[64];
    int          nd;
    out_t        ch;
    neg = 1'b0;
    nd = 0;
    lo = it.value[31:0];
    case (it.mode)
      MODE_DEC: radix = 64'd10;
      MODE_OCT: radix = 64'd8;
      MODE_HEX: radix = 64'd16;
      default:  radix = 64'd2;
    endcase
    if (it.mode == MODE_HEX) begin
      mag = it.value;
    end else if (it.mode != MODE_BIN && lo[31]) begin
      // Negating in 32 bits leaves 2^31 as its own magnitude, which is exact.
      neg = 1'b1;
      mag = {32'b0, -lo};
    end else begin
      mag = {32'b0, lo};
    end
    do begin
      rem = mag % radix;
      digs[nd] = rem[3:0];
      nd++;
      mag = mag / radix;
    end while (mag != 64'd0);
    if (neg) begin
      ch.char_code = CHAR_MINUS;
      ch.last = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      if (digs[k] <= 4'd9) begin
        ch.char_code = CHAR_ZERO + {4'b0, digs[k]};
      end else begin
        ch.char_code = CHAR_A + {4'b0, digs[k]} - 8'd10;
      end
      ch.last = (k == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic in_t random_number();
    in_t it;
    logic [63:0] r;
    r = {$urandom, $urandom};
    it.mode = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 4))
      0: it.value = r;
      1: it.value = r >> $urandom_range(0, 63);
      2: it.value = {r[63:32], 32'($urandom_range(0, 20))};
      3: it.value = {r[63:32], 32'h8000_0000 + 32'($urandom_range(0, 3))};
      default: it.value = {r[63:32], 32'hFFFF_FFFF - 32'($urandom_range(0, 20))};
    endcase
    return it;
  endfunction

  initial begin
    items_to_send.push_back('{MODE_DEC, 64'd0});
    items_to_send.push_back('{MODE_DEC, 64'd9});
    items_to_send.push_back('{MODE_DEC, 64'd10});
    items_to_send.push_back('{MODE_DEC, 64'h0000_0000_7FFF_FFFF});
    items_to_send.push_back('{MODE_DEC, 64'h0000_0000_8000_0000});
    items_to_send.push_back('{MODE_DEC, 64'h0000_0000_FFFF_FFFF});
    items_to_send.push_back('{MODE_DEC, 64'hFFFF_FFFF_0000_0005});
    items_to_send.push_back('{MODE_OCT, 64'd0});
    items_to_send.push_back('{MODE_OCT, 64'd7});
    items_to_send.push_back('{MODE_OCT, 64'd8});
    items_to_send.push_back('{MODE_OCT, 64'h0000_0000_7FFF_FFFF});
    items_to_send.push_back('{MODE_OCT, 64'h0000_0000_8000_0000});
    items_to_send.push_back('{MODE_OCT, 64'hABCD_0000_FFFF_FFFF});
    items_to_send.push_back('{MODE_HEX, 64'd0});
    items_to_send.push_back('{MODE_HEX, 64'h0123_4567_89AB_CDEF});
    items_to_send.push_back('{MODE_HEX, 64'hFEDC_BA98_7654_3210});
    items_to_send.push_back('{MODE_HEX, 64'h8000_0000_0000_0000});
    items_to_send.push_back('{MODE_HEX, 64'hFFFF_FFFF_FFFF_FFFF});
    items_to_send.push_back('{MODE_BIN, 64'd0});
    items_to_send.push_back('{MODE_BIN, 64'd1});
    items_to_send.push_back('{MODE_BIN, 64'h0000_0000_8000_0000});
    items_to_send.push_back('{MODE_BIN, 64'h0000_0000_FFFF_FFFF});
    items_to_send.push_back('{MODE_BIN, 64'hFFFF_FFFF_0000_0000});
    for (int i = 0; i < NUM_RANDOM; i++) begin
      items_to_send.push_back(random_number());
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (items_to_send.size() != 0 || push) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expected_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Driver: presents the next pending number whenever the slot is free, with random idle gaps before the tail.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expand_digits(item_d);
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (items_to_send.size() != 0) begin
          item_d <= items_to_send.pop_front();
          push <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 16);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each character transaction against the oldest expectation and drives pop with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          errors++;
          if (mismatches < 10) begin
            $display("unexpected result: char %h last %b", result_q.char_code, result_q.last);
          end
          mismatches++;
        end else begin
          if (result_q.char_code !== expected_chars[0].char_code ||
              result_q.last !== expected_chars[0].last) begin
            errors++;
            if (mismatches < 10) begin
              $display("mismatch: expected char %h last %b, got char %h last %b",
                       expected_chars[0].char_code, expected_chars[0].last,
                       result_q.char_code, result_q.last);
            end
            mismatches++;
          end
          void'(expected_chars.pop_front());
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) begin
          pop_gap = $urandom_range(1, 16);
        end
      end
    end
  end

  // Watchdog: ends the run if no transaction happens for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
